// ----- hdl/ppdf_pkg.sv -----
// Shared types and constants of the polyline point direction filter.
package ppdf_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REF_X  = 2'd0,
		REG_REF_Y  = 2'd1,
		REG_REF_Z  = 2'd2,
		REG_RADIUS = 2'd3
	} cfg_reg_t;

	// Sequencer states, one-hot
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SQ   = 7'b0000010,
		ST_SUM  = 7'b0000100,
		ST_CMP  = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_SQRT = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	// Control of one direction unit
	typedef struct packed {
		logic load;
		logic div_step;
		logic div_first;
		logic sqrt_step;
	} dir_ctl_t;

endpackage

// ----- hdl/ppdf_sq.sv -----
// Bit-serial squaring unit: one shift-add step per cycle while run is high, W steps per square.
module ppdf_sq #(
	parameter int W = 24
) (
	input  logic           clk,
	input  logic           load,
	input  logic           run,
	input  logic [W-1:0]   op,
	output logic [2*W-1:0] prod
);

	logic [W-1:0]   mcand_q;
	logic [2*W-1:0] acc_q;
	logic [W:0]     upper;

	// add the multiplicand into the upper half when the current multiplier bit is set
	assign upper = {1'b0, acc_q[2*W-1:W]} + (acc_q[0] ? {1'b0, mcand_q} : {(W+1){1'b0}});

	always_ff @(posedge clk) begin
		if (load) begin
			mcand_q <= op;
			acc_q   <= {{W{1'b0}}, op};
		end else if (run) begin
			acc_q <= {upper, acc_q[W-1:1]};
		end
	end

	assign prod = acc_q;

endmodule

// ----- hdl/ppdf_dir.sv -----
// Direction unit: restoring division m^2*4K^2/S, then bit-pair integer root and rounding.
module ppdf_dir #(
	parameter int COORD_BITS = 24,
	parameter int DIR_BITS   = 16
) (
	input  logic                    clk,
	input  ppdf_pkg::dir_ctl_t      ctl,
	input  logic [2*COORD_BITS-1:0] msq,
	input  logic [2*COORD_BITS+1:0] s,
	input  logic                    neg,
	output logic [DIR_BITS-1:0]     dir
);
	import ppdf_pkg::*;

	localparam int SW = 2*COORD_BITS + 2;
	localparam int TW = 2*DIR_BITS + 2;
	localparam int RW = DIR_BITS + 1;
	localparam int MW = DIR_BITS + 4;
	localparam logic [RW-1:0] K_Q  = {1'b0, 1'b1, {(DIR_BITS-1){1'b0}}};
	localparam logic [RW-1:0] K_M1 = {2'b00, {(DIR_BITS-1){1'b1}}};

	logic [SW-1:0]   r_q;
	logic [TW-1:0]   t_q;
	logic [RW-1:0]   root_q;
	logic [MW-3:0]   rem_q;
	logic            neg_q;

	logic [SW:0]     trial;
	logic [SW:0]     diff;
	logic            ge;
	logic [MW-1:0]   pre;
	logic [MW-1:0]   strial;
	logic [MW-1:0]   sdiff;
	logic            sge;
	logic [RW:0]     qsum;
	logic [RW-1:0]   q;
	logic [RW-1:0]   qsat;
	logic [RW-1:0]   qneg;

	// division: the first step compares the unshifted remainder (integer bit)
	assign trial = ctl.div_first ? {1'b0, r_q} : {r_q, 1'b0};
	assign ge    = trial >= {1'b0, s};
	assign diff  = trial - {1'b0, s};

	// root: bring down the next bit pair of the quotient
	assign pre    = {rem_q, t_q[TW-1 -: 2]};
	assign strial = {1'b0, root_q, 2'b01};
	assign sge    = pre >= strial;
	assign sdiff  = pre - strial;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			r_q    <= {2'b00, msq};
			t_q    <= '0;
			root_q <= '0;
			rem_q  <= '0;
			neg_q  <= neg;
		end else if (ctl.div_step) begin
			r_q <= ge ? diff[SW-1:0] : trial[SW-1:0];
			t_q <= {t_q[TW-2:0], ge};
		end else if (ctl.sqrt_step) begin
			rem_q  <= sge ? sdiff[MW-3:0] : pre[MW-3:0];
			root_q <= {root_q[RW-2:0], sge};
			t_q    <= {t_q[TW-3:0], 2'b00};
		end
	end

	// round: q = floor((root + 1) / 2), saturate +K, keep -K
	assign qsum = {1'b0, root_q} + {{RW{1'b0}}, 1'b1};
	assign q    = qsum[RW:1];
	assign qsat = (q == K_Q) ? K_M1 : q;
	assign qneg = -q;
	assign dir  = neg_q ? qneg[DIR_BITS-1:0] : qsat[DIR_BITS-1:0];

endmodule

// ----- hdl/polyline_point_direction_filter_core.sv -----
// Top level of the polyline point direction filter.
//
// Takes map polyline points one beat at a time and drops those whose squared distance to the
// reference position exceeds radius squared; kept points come out with their unit direction from
// the previous input point in signed fixed point with DIR_BITS-1 fraction bits, rounded to nearest
// with ties away from zero (zero on a line start or a zero-length step). The previous point is
// replaced by every accepted point, kept or dropped. One point is in work at a time. After the
// input beat, the offsets are squared bit-serially, then summed and compared: a dropped point
// frees the input after the compare, a kept point without direction goes on to the finish state,
// and a kept point with direction first runs a restoring division for 2*DIR_BITS+1 quotient bits
// and a bit-pair root for DIR_BITS+1 root bits. A result waits in the output register, so a new
// point may enter while the last result is not yet taken; only a second finished result waits
// for the output register to drain.
module polyline_point_direction_filter_core #(
	parameter int COORD_BITS = 24,
	parameter int DIR_BITS   = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ppdf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [COORD_BITS-1:0]                cfg_data,
	// input points
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [COORD_BITS-1:0]         point_x,
	input  logic signed [COORD_BITS-1:0]         point_y,
	input  logic signed [COORD_BITS-1:0]         point_z,
	input  logic                                 line_start,
	// results
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [COORD_BITS-1:0]         out_x,
	output logic signed [COORD_BITS-1:0]         out_y,
	output logic signed [COORD_BITS-1:0]         out_z,
	output logic signed [DIR_BITS-1:0]           dir_x,
	output logic signed [DIR_BITS-1:0]           dir_y,
	output logic signed [DIR_BITS-1:0]           dir_z
);
	import ppdf_pkg::*;

	localparam int SW    = 2*COORD_BITS + 2;
	localparam int QW    = 2*DIR_BITS + 1;
	localparam int MAXI  = (QW > COORD_BITS) ? QW : COORD_BITS;
	localparam int CNT_W = $clog2(MAXI);

	// magnitude of a (COORD_BITS+1)-bit difference; always fits COORD_BITS bits
	function automatic logic [COORD_BITS-1:0] mag_of(input logic [COORD_BITS:0] v);
		logic [COORD_BITS:0] n;
		n = -v;
		return v[COORD_BITS] ? n[COORD_BITS-1:0] : v[COORD_BITS-1:0];
	endfunction

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;

	logic [COORD_BITS-1:0] ref_q  [3];
	logic [COORD_BITS-1:0] radius_q;
	logic [COORD_BITS-1:0] prev_q [3];
	logic [COORD_BITS-1:0] pt_q   [3];
	logic [2:0]            sgn_q;
	logic                  start_q;
	logic                  zero_q;
	logic [SW-1:0]         dist_q;
	logic [SW-1:0]         s_q;

	logic                  out_valid_q;
	logic [COORD_BITS-1:0] out_pt_q  [3];
	logic [DIR_BITS-1:0]   out_dir_q [3];

	logic [COORD_BITS-1:0]   pin  [3];
	logic [COORD_BITS:0]     ediff [3];
	logic [COORD_BITS:0]     ddiff [3];
	logic [COORD_BITS-1:0]   emag [3];
	logic [COORD_BITS-1:0]   dmag [3];
	logic [2*COORD_BITS-1:0] esq  [3];
	logic [2*COORD_BITS-1:0] dsq  [3];
	logic [2*COORD_BITS-1:0] rsq;
	logic [DIR_BITS-1:0]     dirv [3];

	logic     in_fire;
	logic     out_free;
	logic     sq_run;
	logic     keep;
	logic     no_dir;
	dir_ctl_t dctl;

	assign pin[0] = point_x;
	assign pin[1] = point_y;
	assign pin[2] = point_z;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid & in_ready;
	assign out_free  = ~out_valid_q | out_ready;
	assign sq_run    = (state_q == ST_SQ);
	assign keep      = dist_q <= SW'(rsq);
	assign no_dir    = start_q | zero_q;

	// offsets to the reference and steps from the previous point, taken at the input beat
	for (genvar g = 0; g < 3; g++) begin : g_axis
		assign ediff[g] = {pin[g][COORD_BITS-1], pin[g]} - {ref_q[g][COORD_BITS-1], ref_q[g]};
		assign ddiff[g] = {pin[g][COORD_BITS-1], pin[g]} - {prev_q[g][COORD_BITS-1], prev_q[g]};
		assign emag[g]  = mag_of(ediff[g]);
		assign dmag[g]  = mag_of(ddiff[g]);

		ppdf_sq #(.W(COORD_BITS)) u_sq_e (
			.clk  (clk),
			.load (in_fire),
			.run  (sq_run),
			.op   (emag[g]),
			.prod (esq[g])
		);

		ppdf_sq #(.W(COORD_BITS)) u_sq_d (
			.clk  (clk),
			.load (in_fire),
			.run  (sq_run),
			.op   (dmag[g]),
			.prod (dsq[g])
		);

		ppdf_dir #(.COORD_BITS(COORD_BITS), .DIR_BITS(DIR_BITS)) u_dir (
			.clk (clk),
			.ctl (dctl),
			.msq (dsq[g]),
			.s   (s_q),
			.neg (sgn_q[g]),
			.dir (dirv[g])
		);
	end

	ppdf_sq #(.W(COORD_BITS)) u_sq_r (
		.clk  (clk),
		.load (in_fire),
		.run  (sq_run),
		.op   (radius_q),
		.prod (rsq)
	);

	// direction units: load at compare, then divide, then take the root
	always_comb begin
		dctl           = '0;
		dctl.load      = (state_q == ST_CMP);
		dctl.div_step  = (state_q == ST_DIV);
		dctl.div_first = (state_q == ST_DIV) && (cnt_q == CNT_W'(QW-1));
		dctl.sqrt_step = (state_q == ST_SQRT);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SQ;
						cnt_q   <= CNT_W'(COORD_BITS-1);
					end
				end
				ST_SQ: begin
					if (cnt_q == '0) begin
						state_q <= ST_SUM;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SUM: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					// drop far points; skip the direction on a line start or zero step
					priority if (!keep) begin
						state_q <= ST_IDLE;
					end else if (no_dir) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DIV;
						cnt_q   <= CNT_W'(QW-1);
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SQRT;
						cnt_q   <= CNT_W'(DIR_BITS);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// configuration registers and previous point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				ref_q[i]  <= '0;
				prev_q[i] <= '0;
			end
			radius_q <= '1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_REF_X:  ref_q[0] <= cfg_data;
					REG_REF_Y:  ref_q[1] <= cfg_data;
					REG_REF_Z:  ref_q[2] <= cfg_data;
					REG_RADIUS: radius_q <= cfg_data;
					default:    ;
				endcase
			end
			// advance the previous point on every beat, kept or dropped
			if (in_fire) begin
				for (int i = 0; i < 3; i++) begin
					prev_q[i] <= pin[i];
				end
			end
		end
	end

	// per-point payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < 3; i++) begin
				pt_q[i]  <= pin[i];
				sgn_q[i] <= ddiff[i][COORD_BITS];
			end
			start_q <= line_start;
			zero_q  <= (ddiff[0] == '0) && (ddiff[1] == '0) && (ddiff[2] == '0);
		end
		if (state_q == ST_SUM) begin
			dist_q <= SW'(esq[0]) + SW'(esq[1]) + SW'(esq[2]);
			s_q    <= SW'(dsq[0]) + SW'(dsq[1]) + SW'(dsq[2]);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			for (int i = 0; i < 3; i++) begin
				out_pt_q[i]  <= pt_q[i];
				out_dir_q[i] <= no_dir ? '0 : dirv[i];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_pt_q[0];
	assign out_y     = out_pt_q[1];
	assign out_z     = out_pt_q[2];
	assign dir_x     = out_dir_q[0];
	assign dir_y     = out_dir_q[1];
	assign dir_z     = out_dir_q[2];

endmodule

// ----- hdl/ppdf_checker.sv -----
// Port-level checks of the polyline point direction filter, bound to its top level.
module ppdf_checker #(
	parameter int COORD_BITS = 24,
	parameter int DIR_BITS   = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COORD_BITS-1:0] out_x,
	input logic [DIR_BITS-1:0]   dir_x
);

	// one point in work at a time: the input closes right after a beat
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input still open right after a beat");

	// a new result only follows a busy cycle
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without work in progress");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(dir_x)))
		else $error("stalled result dropped or changed");

endmodule

bind polyline_point_direction_filter_core ppdf_checker #(
	.COORD_BITS (COORD_BITS),
	.DIR_BITS   (DIR_BITS)
) u_ppdf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_x     (out_x),
	.dir_x     (dir_x)
);
